// ===== design/sidp_pkg.sv =====
// sidp_pkg: shared types and codes for the set intersect / difference / product engine.
// No dependencies.
`default_nettype none

package sidp_pkg;

    localparam int VALUE_W     = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_PROBE = 2'd2;

    localparam logic [1:0] MODE_INTER = 2'd0;
    localparam logic [1:0] MODE_DIFF  = 2'd1;
    localparam logic [1:0] MODE_PROD  = 2'd2;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               is_run;
    } t_job;

endpackage

`default_nettype wire

// ===== design/sidp_if.sv =====
// sidp_if: valid/ready channel interfaces for request, result and config channels.
// No dependencies.
`default_nettype none

interface sidp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [31:0] element_value;

    modport source (output valid, opcode, element_value, input ready);
    modport sink   (input valid, opcode, element_value, output ready);
endinterface

interface sidp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic               last_of_run;

    modport source (output valid, first_value, second_value, last_of_run, input ready);
    modport sink   (input valid, first_value, second_value, last_of_run, output ready);
endinterface

interface sidp_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== design/sidp_front.sv =====
// sidp_front: accepts requests, holds the B and seen-A stores, classifies probes into jobs.
// Depends on sidp_pkg.
`default_nettype none

module sidp_front #(
    parameter  int SET_DEPTH = 16,
    localparam int CW = $clog2(SET_DEPTH + 1),
    localparam int IW = $clog2(SET_DEPTH)
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [1:0]                       i_mode,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [1:0]                       i_opcode,
    input  wire logic [sidp_pkg::VALUE_W-1:0]     i_value,
    input  wire logic                             i_q_full,
    input  wire logic                             i_q_empty,
    input  wire logic                             i_back_busy,
    output logic                                  o_push,
    output sidp_pkg::t_job                        o_job,
    input  wire logic [IW-1:0]                    i_rd_idx,
    output logic [sidp_pkg::VALUE_W-1:0]          o_rd_data,
    output logic [CW-1:0]                         o_b_cnt
);
    import sidp_pkg::*;

    logic [VALUE_W-1:0] r_b [SET_DEPTH];
    logic [VALUE_W-1:0] r_s [SET_DEPTH];
    logic [CW-1:0]      r_b_cnt, n_b_cnt;
    logic [CW-1:0]      r_s_cnt, n_s_cnt;
    logic [SET_DEPTH-1:0] b_hit_vec, s_hit_vec;
    logic b_hit, s_hit, b_full, s_full;
    logic is_mod, acc, rec_seen, do_load;

    always_comb begin
        for (int i = 0; i < SET_DEPTH; i++) begin
            b_hit_vec[i] = (CW'(i) < r_b_cnt) && (r_b[i] == i_value);
            s_hit_vec[i] = (CW'(i) < r_s_cnt) && (r_s[i] == i_value);
        end
    end

    assign b_hit  = |b_hit_vec;
    assign s_hit  = |s_hit_vec;
    assign b_full = (r_b_cnt == CW'(SET_DEPTH));
    assign s_full = (r_s_cnt == CW'(SET_DEPTH));

    // store updates wait until every queued job has drained
    assign is_mod  = (i_opcode == OP_CLEAR) || (i_opcode == OP_LOAD);
    assign o_ready = !i_q_full && (!is_mod || (i_q_empty && !i_back_busy));
    assign acc     = i_valid && o_ready;
    assign do_load = acc && (i_opcode == OP_LOAD) && !b_hit && !b_full;

    always_comb begin
        o_push       = 1'b0;
        rec_seen     = 1'b0;
        o_job.value  = i_value;
        o_job.is_run = 1'b0;
        if (acc && (i_opcode == OP_PROBE)) begin
            case (i_mode)
                MODE_INTER: begin
                    if (b_hit && !s_hit && !s_full) begin
                        rec_seen = 1'b1;
                        o_push   = 1'b1;
                    end
                end
                MODE_DIFF: begin
                    if (!b_hit) begin
                        o_push = 1'b1;
                    end
                end
                MODE_PROD: begin
                    if (!s_hit && !s_full) begin
                        rec_seen     = 1'b1;
                        o_push       = (r_b_cnt != '0);
                        o_job.is_run = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_b_cnt = r_b_cnt;
        n_s_cnt = r_s_cnt;
        if (acc) begin
            case (i_opcode)
                OP_CLEAR: begin
                    n_b_cnt = '0;
                    n_s_cnt = '0;
                end
                OP_LOAD: begin
                    if (do_load) begin
                        n_b_cnt = r_b_cnt + CW'(1);
                    end
                end
                OP_PROBE: begin
                    if (rec_seen) begin
                        n_s_cnt = r_s_cnt + CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_cnt <= '0;
            r_s_cnt <= '0;
        end else begin
            r_b_cnt <= n_b_cnt;
            r_s_cnt <= n_s_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_b[r_b_cnt[IW-1:0]] <= i_value;
        end
        if (rec_seen) begin
            r_s[r_s_cnt[IW-1:0]] <= i_value;
        end
    end

    assign o_rd_data = r_b[i_rd_idx];
    assign o_b_cnt   = r_b_cnt;

endmodule

`default_nettype wire

// ===== design/sidp_queue.sv =====
// sidp_queue: short job queue between front and back.
// Depends on sidp_pkg.
`default_nettype none

module sidp_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire sidp_pkg::t_job i_job,
    output logic                o_full,
    output logic                o_empty,
    input  wire logic           i_pop,
    output sidp_pkg::t_job      o_job
);
    import sidp_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == NW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + NW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ===== design/sidp_back.sv =====
// sidp_back: executes jobs, walks the B store for product runs, output register stage.
// Depends on sidp_pkg; reads the B store through the front's read port.
`default_nettype none

module sidp_back #(
    parameter  int SET_DEPTH = 16,
    localparam int CW = $clog2(SET_DEPTH + 1),
    localparam int IW = $clog2(SET_DEPTH)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_empty,
    output logic                              o_pop,
    input  wire sidp_pkg::t_job               i_job,
    output logic                              o_busy,
    output logic [IW-1:0]                     o_rd_idx,
    input  wire logic [sidp_pkg::VALUE_W-1:0] i_rd_data,
    input  wire logic [CW-1:0]                i_b_cnt,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [sidp_pkg::VALUE_W-1:0]      o_first,
    output logic [sidp_pkg::VALUE_W-1:0]      o_second,
    output logic                              o_last
);
    import sidp_pkg::*;

    logic               r_busy, r_run, r_ov, r_last;
    logic [VALUE_W-1:0] r_val, r_first, r_second;
    logic [IW-1:0]      r_idx;
    logic               can_load, emit, last;

    assign can_load = !r_ov || i_ready;
    assign emit     = r_busy && can_load;
    assign last     = !r_run || ((CW'(r_idx) + CW'(1)) == i_b_cnt);
    assign o_pop    = !i_q_empty && (!r_busy || (emit && last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_val <= i_job.value;
            r_run <= i_job.is_run;
            r_idx <= '0;
        end else if (emit && !last) begin
            r_idx <= r_idx + IW'(1);
        end
        if (emit) begin
            r_first  <= r_val;
            r_second <= r_run ? i_rd_data : '0;
            r_last   <= last;
        end
    end

    assign o_busy   = r_busy;
    assign o_rd_idx = r_idx;
    assign o_valid  = r_ov;
    assign o_first  = r_first;
    assign o_second = r_second;
    assign o_last   = r_last;

endmodule

`default_nettype wire

// ===== design/set_intersect_difference_product.sv =====
// set_intersect_difference_product: top level, front / queue / back and the mode register.
// Depends on sidp_pkg, sidp_if, sidp_front, sidp_queue, sidp_back.
//
//   channel  | dir | handshake     | payload
//   i_in     | in  | valid / ready | opcode, element_value
//   o_out    | out | valid / ready | first_value, second_value, last_of_run
//   i_cfg    | in  | valid / ready | data (operation_mode)
//
// Front takes one request a cycle; the B and seen-A lookups are parallel compares.
// Jobs pass queue, back job and output regs; back gives one result a cycle unless o_out stalls.
// A run of N product pairs leaves the back pair by pair; requests stall while the queue is full.
// Clear and load requests stall until the queue and back have drained.
// Synchronous active-low reset empties the stores (counts to zero) and sets intersection mode.
`default_nettype none

module set_intersect_difference_product #(
    parameter int SET_DEPTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sidp_in_if.sink    i_in,
    sidp_out_if.source o_out,
    sidp_cfg_if.sink   i_cfg
);
    import sidp_pkg::*;

    localparam int CW = $clog2(SET_DEPTH + 1);
    localparam int IW = $clog2(SET_DEPTH);

    logic [1:0]         r_mode;
    logic               q_full, q_empty, push, pop, back_busy;
    t_job               push_job, pop_job;
    logic [IW-1:0]      rd_idx;
    logic [VALUE_W-1:0] rd_data, first_v, second_v;
    logic [CW-1:0]      b_cnt;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_INTER;
        end else if (i_cfg.valid) begin
            r_mode <= i_cfg.data;
        end
    end

    sidp_front #(.SET_DEPTH(SET_DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_mode),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_opcode    (i_in.opcode),
        .i_value     (i_in.element_value),
        .i_q_full    (q_full),
        .i_q_empty   (q_empty),
        .i_back_busy (back_busy),
        .o_push      (push),
        .o_job       (push_job),
        .i_rd_idx    (rd_idx),
        .o_rd_data   (rd_data),
        .o_b_cnt     (b_cnt)
    );

    sidp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_empty (q_empty),
        .i_pop   (pop),
        .o_job   (pop_job)
    );

    sidp_back #(.SET_DEPTH(SET_DEPTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .o_pop     (pop),
        .i_job     (pop_job),
        .o_busy    (back_busy),
        .o_rd_idx  (rd_idx),
        .i_rd_data (rd_data),
        .i_b_cnt   (b_cnt),
        .o_valid   (o_out.valid),
        .i_ready   (o_out.ready),
        .o_first   (first_v),
        .o_second  (second_v),
        .o_last    (o_out.last_of_run)
    );

    assign o_out.first_value  = first_v;
    assign o_out.second_value = second_v;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_full))
        else $error("push into full queue");

    a_store_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.opcode == OP_CLEAR || i_in.opcode == OP_LOAD))
        |-> (q_empty && !back_busy))
        else $error("store update while jobs pending");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last_of_run) |=> o_out.valid)
        else $error("product run broken");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== dv/set_intersect_difference_product_test.sv =====
// Testbench for set_intersect_difference_product: directed table, store overfill, then
// random request sequences under four idling plans, checked against a behavioural set engine.
// Depends on sidp_pkg, sidp_if and the design top level.
`timescale 1ns / 100ps

module set_intersect_difference_product_test;

    import sidp_pkg::*;

    localparam int          SET_DEPTH    = 16;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          PHASE_ITEMS  = 40;
    localparam int          LIMIT_NS     = 2_000_000;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;
    localparam logic [31:0] VMIN         = 32'h8000_0000;
    localparam logic [31:0] VMAX         = 32'h7FFF_FFFF;
    localparam logic [31:0] ALL1         = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] a_part;
        logic [31:0] b_part;
        logic        last;
    } t_pair;

    typedef enum logic {ROW_REQ, ROW_MODE} t_row_kind;

    // code is the opcode for a request row, the mode for a mode row;
    // n_typed < 0 means the row is checked against the predictor
    typedef struct {
        t_row_kind   kind;
        logic [1:0]  code;
        logic [31:0] value;
        int          n_typed;
        t_pair       typed;
    } t_dir_row;

    localparam int N_DIR = 28;

    logic i_clk;
    logic i_rst_n;

    sidp_in_if  in_bus ();
    sidp_out_if out_bus ();
    sidp_cfg_if cfg_bus ();

    set_intersect_difference_product #(.SET_DEPTH(SET_DEPTH)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    logic [31:0] b_set    [SET_DEPTH];
    logic [31:0] seen_set [SET_DEPTH];
    int          b_len    = 0;
    int          seen_len = 0;
    logic [1:0]  mode_reg = MODE_INTER;

    t_pair expected_pairs [$];
    t_pair emitted_pairs  [$];

    int errors         = 0;
    int reqs_sent      = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    t_dir_row dir_rows [N_DIR] = '{
        '{ROW_REQ,  OP_PROBE,    32'd5,         0, '0},
        '{ROW_REQ,  OP_LOAD,     VMIN,          0, '0},
        '{ROW_REQ,  OP_LOAD,     VMAX,          0, '0},
        '{ROW_REQ,  OP_LOAD,     VMAX,          0, '0},
        '{ROW_REQ,  OP_LOAD,     32'd0,         0, '0},
        '{ROW_REQ,  OP_LOAD,     ALL1,          0, '0},
        '{ROW_REQ,  OP_PROBE,    VMIN,          1, '{VMIN, 32'd0, 1'b1}},
        '{ROW_REQ,  OP_PROBE,    VMIN,          0, '0},
        '{ROW_REQ,  OP_PROBE,    VMAX,          1, '{VMAX, 32'd0, 1'b1}},
        '{ROW_REQ,  OP_PROBE,    32'd7,         0, '0},
        '{ROW_REQ,  OP_UNUSED,   ALL1,          0, '0},
        '{ROW_MODE, MODE_DIFF,   32'd0,         0, '0},
        '{ROW_REQ,  OP_PROBE,    32'd7,         1, '{32'd7, 32'd0, 1'b1}},
        '{ROW_REQ,  OP_PROBE,    32'd7,         1, '{32'd7, 32'd0, 1'b1}},
        '{ROW_REQ,  OP_PROBE,    ALL1,          0, '0},
        '{ROW_REQ,  OP_PROBE,    32'h5555_AAAA, 1, '{32'h5555_AAAA, 32'd0, 1'b1}},
        '{ROW_MODE, MODE_PROD,   32'd0,         0, '0},
        '{ROW_REQ,  OP_PROBE,    32'd0,        -1, '0},
        '{ROW_REQ,  OP_PROBE,    VMAX,          0, '0},
        '{ROW_REQ,  OP_CLEAR,    32'd0,         0, '0},
        '{ROW_REQ,  OP_PROBE,    32'd3,         0, '0},
        '{ROW_REQ,  OP_LOAD,     32'd9,         0, '0},
        '{ROW_REQ,  OP_PROBE,    32'd3,         0, '0},
        '{ROW_REQ,  OP_PROBE,    32'd4,         1, '{32'd4, 32'd9, 1'b1}},
        '{ROW_MODE, MODE_UNUSED, 32'd0,         0, '0},
        '{ROW_REQ,  OP_PROBE,    32'd11,        0, '0},
        '{ROW_REQ,  OP_LOAD,     32'hAAAA_5555, 0, '0},
        '{ROW_REQ,  OP_PROBE,    32'd9,         0, '0}
    };

    function automatic bit member(input logic [31:0] store [SET_DEPTH], input int len,
                                  input logic [31:0] v);
        for (int i = 0; i < len; i++)
            if (store[i] == v) return 1'b1;
        return 1'b0;
    endfunction

    // updates the stores and fills emitted_pairs with what the request gives
    function automatic void apply_set_request(input logic [1:0] op, input logic [31:0] v);
        emitted_pairs.delete();
        case (op)
            OP_CLEAR: begin
                b_len    = 0;
                seen_len = 0;
            end
            OP_LOAD: begin
                if (!member(b_set, b_len, v) && b_len < SET_DEPTH) begin
                    b_set[b_len] = v;
                    b_len++;
                end
            end
            OP_PROBE: begin
                case (mode_reg)
                    MODE_INTER: begin
                        if (member(b_set, b_len, v) && !member(seen_set, seen_len, v)
                                && seen_len < SET_DEPTH) begin
                            seen_set[seen_len] = v;
                            seen_len++;
                            emitted_pairs.push_back('{v, 32'd0, 1'b1});
                        end
                    end
                    MODE_DIFF: begin
                        if (!member(b_set, b_len, v))
                            emitted_pairs.push_back('{v, 32'd0, 1'b1});
                    end
                    MODE_PROD: begin
                        if (!member(seen_set, seen_len, v) && seen_len < SET_DEPTH) begin
                            seen_set[seen_len] = v;
                            seen_len++;
                            for (int j = 0; j < b_len; j++)
                                emitted_pairs.push_back('{v, b_set[j], j == b_len - 1});
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 3))
                    0: return VMIN;
                    1: return VMAX;
                    2: return 32'd0;
                    default: return ALL1;
                endcase
            end
            1: return 32'($urandom_range(0, 15)) - 32'd8;
            default: return $urandom;
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_req(input logic [1:0] op, input logic [31:0] v);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid         = 1'b1;
        in_bus.opcode        = op;
        in_bus.element_value = v;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic issue(input logic [1:0] op, input logic [31:0] v);
        apply_set_request(op, v);
        foreach (emitted_pairs[i]) expected_pairs.push_back(emitted_pairs[i]);
        reqs_sent++;
        send_req(op, v);
    endtask

    task automatic settle(input int extra);
        in_bus.valid = 1'b0;
        while (expected_pairs.size() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        cfg_bus.valid = 1'b1;
        cfg_bus.data  = m;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        mode_reg = m;
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_bus.ready = ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_pair want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (expected_pairs.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0d %0d %0b", $time,
                         out_bus.first_value, out_bus.second_value, out_bus.last_of_run);
                errors++;
            end else begin
                want = expected_pairs.pop_front();
                if (out_bus.first_value !== want.a_part) begin
                    $display("%0t: first_value expected %0d got %0d", $time,
                             $signed(want.a_part), out_bus.first_value);
                    errors++;
                end
                if (out_bus.second_value !== want.b_part) begin
                    $display("%0t: second_value expected %0d got %0d", $time,
                             $signed(want.b_part), out_bus.second_value);
                    errors++;
                end
                if (out_bus.last_of_run !== want.last) begin
                    $display("%0t: last_of_run expected %0b got %0b", $time,
                             want.last, out_bus.last_of_run);
                    errors++;
                end
            end
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    initial begin
        int          idle_plan [4][2] = '{'{0, 0}, '{45, 0}, '{0, 45}, '{29, 29}};
        logic [1:0]  mode_plan [3]    = '{MODE_INTER, MODE_DIFF, MODE_PROD};
        logic [31:0] pool [8];
        int          phase_end;
        int          n_load;
        int          n_probe;
        bit          paused;

        i_rst_n              = 1'b0;
        in_bus.valid         = 1'b0;
        in_bus.opcode        = OP_CLEAR;
        in_bus.element_value = '0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.data         = MODE_INTER;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        write_mode(MODE_INTER);
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_MODE) begin
                settle(DRAIN_CYCLES);
                write_mode(dir_rows[i].code);
            end else begin
                apply_set_request(dir_rows[i].code, dir_rows[i].value);
                if (dir_rows[i].n_typed < 0)
                    foreach (emitted_pairs[k]) expected_pairs.push_back(emitted_pairs[k]);
                else if (dir_rows[i].n_typed == 1)
                    expected_pairs.push_back(dir_rows[i].typed);
                reqs_sent++;
                send_req(dir_rows[i].code, dir_rows[i].value);
            end
        end

        // overfill both stores: full product runs, then drops once seen store is full
        settle(DRAIN_CYCLES);
        write_mode(MODE_PROD);
        issue(OP_CLEAR, 32'd0);
        for (int k = 0; k < SET_DEPTH + 2; k++) issue(OP_LOAD, 32'h1000_0000 + k);
        for (int k = 0; k < SET_DEPTH + 2; k++) issue(OP_PROBE, 32'h2000_0000 + k);
        settle(DRAIN_CYCLES);
        write_mode(MODE_INTER);
        for (int k = 0; k < 3; k++) issue(OP_PROBE, 32'h1000_0000 + k);

        for (int p = 0; p < 4; p++) begin
            for (int q = 0; q < 3; q++) begin
                settle(DRAIN_CYCLES);
                write_mode(mode_plan[(p + q) % 3]);
                src_idle_pct   = idle_plan[p][0];
                sink_stall_pct = idle_plan[p][1];
                phase_end      = reqs_sent + PHASE_ITEMS;
                paused         = 1'b0;
                while (reqs_sent < phase_end) begin
                    if (!paused && reqs_sent >= phase_end - PHASE_ITEMS / 2) begin
                        settle(1);
                        paused = 1'b1;
                    end
                    if ($urandom_range(0, 9) == 0) begin
                        issue(2'($urandom_range(0, 2)), rand_value());
                    end else begin
                        foreach (pool[i]) pool[i] = rand_value();
                        if ($urandom_range(0, 3) != 0) issue(OP_CLEAR, rand_value());
                        n_load = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20)
                                                             : $urandom_range(1, 5);
                        for (int k = 0; k < n_load; k++)
                            issue(OP_LOAD, ($urandom_range(0, 1) == 0)
                                           ? rand_value() : pool[$urandom_range(0, 7)]);
                        n_probe = $urandom_range(1, 8);
                        for (int k = 0; k < n_probe; k++)
                            issue(OP_PROBE, ($urandom_range(0, 3) == 0)
                                            ? rand_value() : pool[$urandom_range(0, 7)]);
                    end
                end
            end
        end

        settle(DRAIN_CYCLES);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
